/* hdl/gbfs_pkg.sv */
// Shared types and constants for the breadth-first order block.
// Used by the controller, the datapath and the top level; no dependencies.
package gbfs_pkg;

   localparam int VERTEX_W = 6;
   localparam int ROW_W    = 64;
   localparam int CSR_W    = 7;
   localparam logic [CSR_W-1:0] VCOUNT_RESET = 7'd64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_row;   // store the incoming row
      logic init;       // clear visited set and queue pointers
      logic enq;        // enqueue the lowest candidate vertex
      logic use_row;    // candidates come from the fetched row
      logic rd_queue;   // read the queue at head
      logic rd_row;     // latch current vertex, read its row
      logic emit;       // load the output register, advance head
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic cand_any;   // some candidate vertex remains
      logic more;       // queue not empty after this pop
      logic out_free;   // output register can take a result
   } sts_type;

endpackage

/* hdl/gbfs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/gbfs_ctrl.sv */
// Traversal controller: sequences row loading and the breadth-first walk.
// Depends on gbfs_pkg for the command and status structs.
module gbfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last_row,
   output logic             req_stall,
   input  gbfs_pkg::sts_type sts,
   output gbfs_pkg::cmd_type cmd
);
   import gbfs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_INIT  = 3'd1;
   localparam logic [2:0] ST_FIND  = 3'd2;
   localparam logic [2:0] ST_RDQ   = 3'd3;
   localparam logic [2:0] ST_RDROW = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_row = 1'b1;
               if (req_last_row) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_FIND;
         end
         ST_FIND: begin
            // lowest unvisited vertex starts a new component
            if (sts.cand_any) begin
               cmd.enq  = 1'b1;
               state_in = ST_RDQ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RDQ: begin
            cmd.rd_queue = 1'b1;
            state_in     = ST_RDROW;
         end
         ST_RDROW: begin
            cmd.rd_row = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.use_row = 1'b1;
            if (sts.cand_any) begin
               cmd.enq = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register frees up
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.more ? ST_RDQ : ST_FIND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/gbfs_dpath.sv */
// Traversal datapath: adjacency and queue RAMs, visited set, pointers,
// lowest-candidate encoder and the output register.
// Depends on gbfs_pkg and gbfs_ram.
module gbfs_dpath #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gbfs_pkg::cmd_type              cmd,
   output gbfs_pkg::sts_type              sts,
   input  logic [gbfs_pkg::VERTEX_W-1:0]  req_row_index,
   input  logic [gbfs_pkg::ROW_W-1:0]     req_row_bits,
   input  logic                           csr_wr_en,
   input  logic [gbfs_pkg::CSR_W-1:0]     csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gbfs_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                           rsp_is_last
);
   import gbfs_pkg::*;

   localparam int IW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CSR_W-1:0] MAX_V = CSR_W'(MAX_VERTICES);

   logic [CSR_W-1:0]        vcount_ff, vcount_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [MAX_VERTICES-1:0] mask_ff, mask_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [CW-1:0]           head_ff, head_in;
   logic [CW-1:0]           tail_ff, tail_in;
   logic [IW-1:0]           cur_ff, cur_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic                    rsp_is_last_ff, rsp_is_last_in;

   logic [CSR_W-1:0]        n_sat;
   logic                    row_ok;
   logic [MAX_VERTICES-1:0] adj_rdata;
   logic [IW-1:0]           q_rdata;
   logic [MAX_VERTICES-1:0] cand;
   logic [MAX_VERTICES-1:0] lowest;
   logic [IW-1:0]           pick_idx;
   logic [CW-1:0]           head_next;

   assign row_ok = ({1'b0, req_row_index} < MAX_V);

   gbfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
      .clock   (clock),
      .wr_en   (cmd.load_row & row_ok),
      .wr_addr (req_row_index[IW-1:0]),
      .wr_data (req_row_bits[MAX_VERTICES-1:0]),
      .rd_en   (cmd.rd_row),
      .rd_addr (q_rdata),
      .rd_data (adj_rdata)
   );

   gbfs_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_queue_ram (
      .clock   (clock),
      .wr_en   (cmd.enq),
      .wr_addr (tail_ff[IW-1:0]),
      .wr_data (pick_idx),
      .rd_en   (cmd.rd_queue),
      .rd_addr (head_ff[IW-1:0]),
      .rd_data (q_rdata)
   );

   // Candidates: unvisited vertices in use, limited to neighbours while scanning
   always_comb begin
      cand   = (cmd.use_row ? adj_rdata : '1) & ~visited_ff & mask_ff;
      lowest = cand & (~cand + MAX_VERTICES'(1));
      pick_idx = '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         if (lowest[i]) begin
            pick_idx = pick_idx | IW'(i);
         end
      end
   end

   assign n_sat     = (vcount_ff > MAX_V) ? MAX_V : vcount_ff;
   assign head_next = CW'(head_ff + CW'(1));

   assign sts.cand_any = |cand;
   assign sts.more     = (head_next != tail_ff);
   assign sts.out_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      vcount_in      = csr_wr_en ? csr_wr_data : vcount_ff;
      n_in           = n_ff;
      mask_in        = mask_ff;
      visited_in     = visited_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      cur_in         = cmd.rd_row ? q_rdata : cur_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_vertex_in  = rsp_vertex_ff;
      rsp_is_last_in = rsp_is_last_ff;

      if (cmd.init) begin
         n_in       = CW'(n_sat);
         visited_in = '0;
         head_in    = '0;
         tail_in    = '0;
         for (int i = 0; i < MAX_VERTICES; i++) begin
            mask_in[i] = (CSR_W'(i) < n_sat);
         end
      end
      if (cmd.enq) begin
         visited_in = visited_ff | lowest;
         tail_in    = CW'(tail_ff + CW'(1));
      end
      if (cmd.emit) begin
         head_in        = head_next;
         rsp_valid_in   = 1'b1;
         rsp_vertex_in  = VERTEX_W'(cur_ff);
         rsp_is_last_in = (head_next == n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= VCOUNT_RESET;
         visited_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         n_ff         <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         visited_ff   <= visited_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         n_ff         <= n_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_vertex_ff  <= rsp_vertex_in;
      rsp_is_last_ff <= rsp_is_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_vertex  = rsp_vertex_ff;
   assign rsp_is_last = rsp_is_last_ff;

endmodule

/* hdl/graph_bfs_order_adjacency_matrix.sv */
// Breadth-first visit order over an adjacency matrix.
// Requests carry one adjacency row each (req_row_index, req_row_bits); a
// request with req_last_row set stores its row and then starts a traversal
// of the first vertex_count vertices, covering every component.
// Responses give each vertex in visit order on rsp_vertex, with rsp_is_last
// set on the final one. The csr_ port writes vertex_count (reset 64,
// saturates at MAX_VERTICES); write it only while the block is idle.
// Rows load at one request per cycle while the block is idle and persist
// across traversals. During a traversal req_stall stays high. The walk
// has setup steps, a step per component start, then per vertex a queue
// read, a row read, the scan end and the output load, and a step per
// neighbour enqueued: the single read port of each RAM and the
// one-vertex-a-cycle enqueue loop set this sequence.
// A stalled response holds the output register and the walk waits on it;
// after the last vertex is loaded, new rows are taken while it waits.
// Reset is synchronous: it clears the controller, visited set, pointers and
// output valid, and restores vertex_count; RAM contents are not cleared.
// Depends on gbfs_pkg, gbfs_ctrl, gbfs_dpath and gbfs_ram.
module graph_bfs_order_adjacency_matrix #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gbfs_pkg::VERTEX_W-1:0]  req_row_index,
   input  logic [gbfs_pkg::ROW_W-1:0]     req_row_bits,
   input  logic                           req_last_row,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [gbfs_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                           rsp_is_last,
   input  logic                           csr_wr_en,
   input  logic [gbfs_pkg::CSR_W-1:0]     csr_wr_data
);
   import gbfs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gbfs_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_row (req_last_row),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   gbfs_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_row_index (req_row_index),
      .req_row_bits  (req_row_bits),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_vertex    (rsp_vertex),
      .rsp_is_last   (rsp_is_last)
   );

endmodule
